FILE: rtl/fnq_pkg.sv
// Package for the face normal Q15 unit: widths, bus types and pipeline constants.
// No dependencies; all rtl files reference it by scoped names.
`default_nettype none
package fnq_pkg;
    localparam int COORD_W   = 17;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = 2 * COORD_W + 1;
    localparam int LO_W      = (MAG_W + 1) / 2;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int S_W       = SQ_W + 2;
    localparam int Q_W       = 15;
    localparam int ACC_W     = S_W + 2 * Q_W + 1;
    localparam int Y_SH      = 2 * (Q_W - 1);
    localparam int Y_W       = S_W + Y_SH;
    localparam int SCALE_HI  = 30;   // 32767^2 = 2^30 - 2^16 + 1
    localparam int SCALE_MID = 16;
    localparam int MAT_W     = 6;
    localparam int SPM_W     = 6;
    localparam int SHADE_W   = 11;
    localparam int SHADE_BASE = 8;
    localparam int SHADE_MAX  = 2047;
    localparam int IN_BITS   = 9 * COORD_W + MAT_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W     = 64;
    localparam int NORM_W    = 16;
    localparam int N_FRONT   = 6;
    localparam int N_CELL    = Q_W;
    localparam int N_STAGE   = N_FRONT + N_CELL + 1;
    localparam logic [SPM_W-1:0] SPM_RESET = 6'd8;

    typedef logic [SQ_W-1:0]  t_sq;
    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [Y_W-1:0]   t_y;
    typedef logic [S_W-1:0]   t_s;

    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [ACC_W-1:0] xacc;
        logic [Q_W-1:0]   k;
    } t_lane;

    typedef struct packed {
        logic [SHADE_W-1:0] shade;
        logic               deg;
        logic [2:0]         neg;
    } t_side;

    typedef struct packed {
        t_lane [2:0]    lane;
        logic [Y_W-1:0] y;
        logic [S_W-1:0] s;
        t_side          side;
    } t_cell_bus;
endpackage
`default_nettype wire

FILE: rtl/fnq_front.sv
// Front end: edge vectors, cross product, squares, |n|^2 and scaled targets.
// Six pipeline stages; depends on fnq_pkg.
`default_nettype none
module fnq_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [fnq_pkg::N_FRONT-1:0]    i_ld,
    input  wire logic                           i_valid,
    input  wire logic [fnq_pkg::IN_W-1:0]       i_tdata,
    input  wire logic [fnq_pkg::SPM_W-1:0]      i_spm,
    output logic      [fnq_pkg::N_FRONT-1:0]    o_valid,
    output fnq_pkg::t_cell_bus                  o_bus
);
    localparam int CW = fnq_pkg::COORD_W;

    logic [fnq_pkg::N_FRONT-1:0] r_v;
    fnq_pkg::t_side r_side [fnq_pkg::N_FRONT];

    logic signed [fnq_pkg::DIFF_W-1:0] n_u [3], n_w [3], r_u [3], r_w [3];
    logic signed [fnq_pkg::PROD_W-1:0] r_p [6];
    logic        [fnq_pkg::MAG_W-1:0]  r_mag [3];
    logic [2*fnq_pkg::HI_W-1:0]            r_hh [3];
    logic [fnq_pkg::HI_W+fnq_pkg::LO_W-1:0] r_hl [3];
    logic [2*fnq_pkg::LO_W-1:0]            r_ll [3];
    logic [fnq_pkg::SQ_W-1:0]  r_sq [3];
    fnq_pkg::t_acc             r_t [3];
    logic [fnq_pkg::S_W-1:0]   r_s;

    logic signed [fnq_pkg::CROSS_W-1:0] n_c [3];
    logic [2*fnq_pkg::MAT_W:0]          n_prod;
    logic [2*fnq_pkg::MAT_W+1:0]        n_shade_sum;
    logic [fnq_pkg::SHADE_W-1:0]        n_shade;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = {i_tdata[(3+i)*CW+CW-1], i_tdata[(3+i)*CW +: CW]}
                   - {i_tdata[i*CW+CW-1], i_tdata[i*CW +: CW]};
            n_w[i] = {i_tdata[(6+i)*CW+CW-1], i_tdata[(6+i)*CW +: CW]}
                   - {i_tdata[i*CW+CW-1], i_tdata[i*CW +: CW]};
        end
        n_prod = (2*fnq_pkg::MAT_W+1)'(i_tdata[9*CW +: fnq_pkg::MAT_W] * i_spm);
        n_shade_sum = {1'b0, n_prod} + (2*fnq_pkg::MAT_W+2)'(fnq_pkg::SHADE_BASE);
        if (n_shade_sum > (2*fnq_pkg::MAT_W+2)'(fnq_pkg::SHADE_MAX)) begin
            n_shade = fnq_pkg::SHADE_W'(fnq_pkg::SHADE_MAX);
        end else begin
            n_shade = n_shade_sum[fnq_pkg::SHADE_W-1:0];
        end
        // cross: x = uy*wz - uz*wy, y = uz*wx - ux*wz, z = ux*wy - uy*wx
        for (int i = 0; i < 3; i++) begin
            n_c[i] = {r_p[2*i][fnq_pkg::PROD_W-1], r_p[2*i]}
                   - {r_p[2*i+1][fnq_pkg::PROD_W-1], r_p[2*i+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < fnq_pkg::N_FRONT; j++) begin
                if (i_ld[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_u <= n_u;
            r_w <= n_w;
            r_side[0] <= '{shade: n_shade, deg: 1'b0, neg: 3'b000};
        end
        if (i_ld[1]) begin
            r_p[0] <= r_u[1] * r_w[2];
            r_p[1] <= r_u[2] * r_w[1];
            r_p[2] <= r_u[2] * r_w[0];
            r_p[3] <= r_u[0] * r_w[2];
            r_p[4] <= r_u[0] * r_w[1];
            r_p[5] <= r_u[1] * r_w[0];
            r_side[1] <= r_side[0];
        end
        if (i_ld[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= n_c[i][fnq_pkg::CROSS_W-1] ? fnq_pkg::MAG_W'(-n_c[i])
                                                       : fnq_pkg::MAG_W'(n_c[i]);
            end
            r_side[2].shade <= r_side[1].shade;
            r_side[2].deg   <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
            r_side[2].neg   <= {n_c[2][fnq_pkg::CROSS_W-1], n_c[1][fnq_pkg::CROSS_W-1],
                                n_c[0][fnq_pkg::CROSS_W-1]};
        end
        if (i_ld[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= r_mag[i][fnq_pkg::MAG_W-1:fnq_pkg::LO_W]
                         * r_mag[i][fnq_pkg::MAG_W-1:fnq_pkg::LO_W];
                r_hl[i] <= r_mag[i][fnq_pkg::MAG_W-1:fnq_pkg::LO_W]
                         * r_mag[i][fnq_pkg::LO_W-1:0];
                r_ll[i] <= r_mag[i][fnq_pkg::LO_W-1:0] * r_mag[i][fnq_pkg::LO_W-1:0];
            end
            r_side[3] <= r_side[2];
        end
        if (i_ld[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (fnq_pkg::t_sq'(r_hh[i]) << (2*fnq_pkg::LO_W))
                         + (fnq_pkg::t_sq'(r_hl[i]) << (fnq_pkg::LO_W+1))
                         + fnq_pkg::t_sq'(r_ll[i]);
            end
            r_side[4] <= r_side[3];
        end
        if (i_ld[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= (fnq_pkg::t_acc'(r_sq[i]) << fnq_pkg::SCALE_HI)
                        - (fnq_pkg::t_acc'(r_sq[i]) << fnq_pkg::SCALE_MID)
                        + fnq_pkg::t_acc'(r_sq[i]);
            end
            r_s <= fnq_pkg::t_s'(r_sq[0]) + fnq_pkg::t_s'(r_sq[1]) + fnq_pkg::t_s'(r_sq[2]);
            r_side[5] <= r_side[4];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_bus.lane[i].rem  = r_t[i];
            o_bus.lane[i].xacc = '0;
            o_bus.lane[i].k    = '0;
        end
        o_bus.y    = fnq_pkg::t_y'(r_s) << fnq_pkg::Y_SH;
        o_bus.s    = r_s;
        o_bus.side = r_side[5];
    end

    assign o_valid = r_v;
endmodule
`default_nettype wire

FILE: rtl/fnq_cell.sv
// One quotient-bit cell: decides one bit of round-down(32767*|n_i|/|n|) for all
// three lanes by shift-and-subtract, then hands its state on. Depends on fnq_pkg.
`default_nettype none
module fnq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ld,
    input  wire logic               i_valid,
    input  wire fnq_pkg::t_cell_bus i_bus,
    output logic                    o_valid,
    output fnq_pkg::t_cell_bus      o_bus
);
    logic               r_v;
    fnq_pkg::t_cell_bus r_bus, n_bus;
    logic [fnq_pkg::ACC_W:0] n_d [3];
    logic                    n_take [3];

    // rem = T - k^2 s, xacc = 2^(b+1) k s, y = 2^(2b) s; try bit b: k^2 s grows by xacc + y
    always_comb begin
        n_bus = i_bus;
        for (int l = 0; l < 3; l++) begin
            n_d[l] = {1'b0, i_bus.lane[l].xacc} + {1'b0, fnq_pkg::t_acc'(i_bus.y)};
            n_take[l] = n_d[l] <= {1'b0, i_bus.lane[l].rem};
            n_bus.lane[l].rem  = n_take[l] ? i_bus.lane[l].rem - n_d[l][fnq_pkg::ACC_W-1:0]
                                           : i_bus.lane[l].rem;
            n_bus.lane[l].xacc = (i_bus.lane[l].xacc >> 1)
                               + (n_take[l] ? fnq_pkg::t_acc'(i_bus.y) : '0);
            n_bus.lane[l].k    = {i_bus.lane[l].k[fnq_pkg::Q_W-2:0], n_take[l]};
        end
        n_bus.y = i_bus.y >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ld) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_v;
    assign o_bus   = r_bus;
endmodule
`default_nettype wire

FILE: rtl/fnq_round.sv
// Final cell: round to nearest, ties to even, apply sign, zero degenerate normals.
// Holds the output register. Depends on fnq_pkg.
`default_nettype none
module fnq_round (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_ld,
    input  wire logic                       i_valid,
    input  wire fnq_pkg::t_cell_bus         i_bus,
    output logic                            o_valid,
    output logic [fnq_pkg::OUT_W-1:0]       o_tdata,
    output logic                            o_tuser
);
    logic                      r_v;
    logic [fnq_pkg::OUT_W-1:0] r_tdata;
    logic                      r_tuser;
    logic [fnq_pkg::ACC_W+2:0] n_lhs [3], n_rhs [3];
    logic                      n_up [3];
    logic [fnq_pkg::NORM_W-1:0] n_q [3], n_o [3];

    // 4T - (2k+1)^2 s = 4 rem - 4 xacc - s, with xacc = k s after the last bit
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_lhs[l] = {1'b0, i_bus.lane[l].rem, 2'b00};
            n_rhs[l] = {1'b0, i_bus.lane[l].xacc, 2'b00}
                     + (fnq_pkg::ACC_W+3)'(i_bus.s);
            n_up[l]  = (n_lhs[l] > n_rhs[l])
                    || ((n_lhs[l] == n_rhs[l]) && i_bus.lane[l].k[0]);
            n_q[l]   = {1'b0, i_bus.lane[l].k} + fnq_pkg::NORM_W'(n_up[l]);
            if (i_bus.side.deg) begin
                n_o[l] = '0;
            end else if (i_bus.side.neg[l]) begin
                n_o[l] = -n_q[l];
            end else begin
                n_o[l] = n_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ld) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_tdata <= fnq_pkg::OUT_W'({i_bus.side.shade, n_o[2], n_o[1], n_o[0]});
            r_tuser <= i_bus.side.deg;
        end
    end

    assign o_valid = r_v;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;
endmodule
`default_nettype wire

FILE: rtl/face_normal_q15_unit.sv
// Face normal Q15 unit: pipeline of 6 front stages, 15 quotient-bit cells and
// 1 rounding/output stage. Throughput one triangle per cycle when not stalled;
// every stage moves when it is empty or the stage after it moves, so bubbles
// close up under output backpressure. Synchronous active-low reset empties the
// pipeline and sets the shade-per-material register r_spm to 8.
`default_nettype none
module face_normal_q15_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fnq_pkg::SPM_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (17 b each), material (6 b), pad
    input  wire logic [fnq_pkg::IN_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // normal_x, normal_y, normal_z (16 b each), base_shade (11 b), pad
    output logic [fnq_pkg::OUT_W-1:0]        o_m_tdata,
    // degenerate
    output logic                             o_m_tuser
);
    localparam int NF = fnq_pkg::N_FRONT;
    localparam int NC = fnq_pkg::N_CELL;
    localparam int NS = fnq_pkg::N_STAGE;

    logic [fnq_pkg::SPM_W-1:0] r_spm;
    logic [NS-1:0] w_v;
    logic [NS:0]   w_ld;
    fnq_pkg::t_cell_bus w_bus [NC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= fnq_pkg::SPM_RESET;
        end else if (i_cfg_we) begin
            r_spm <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_ld[NS] = i_m_tready;
        for (int j = NS - 1; j >= 0; j--) begin
            w_ld[j] = !w_v[j] || w_ld[j+1];
        end
    end

    fnq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld[NF-1:0]),
        .i_valid (i_s_tvalid),
        .i_tdata (i_s_tdata),
        .i_spm   (r_spm),
        .o_valid (w_v[NF-1:0]),
        .o_bus   (w_bus[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        fnq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ld    (w_ld[NF+g]),
            .i_valid (w_v[NF+g-1]),
            .i_bus   (w_bus[g]),
            .o_valid (w_v[NF+g]),
            .o_bus   (w_bus[g+1])
        );
    end

    fnq_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld[NS-1]),
        .i_valid (w_v[NS-2]),
        .i_bus   (w_bus[NC]),
        .o_valid (w_v[NS-1]),
        .o_tdata (o_m_tdata),
        .o_tuser (o_m_tuser)
    );

    assign o_s_tready = w_ld[0];
    assign o_m_tvalid = w_v[NS-1];
endmodule
`default_nettype wire
